// File: src/manning_cell_flow_update_top_defines.svh
// assertion macros for the manning cell flow block
`ifndef MANNING_CELL_FLOW_UPDATE_TOP_DEFINES_SVH
`define MANNING_CELL_FLOW_UPDATE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCFU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// plain condition checked on every edge
`define MCFU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// File: src/mcfu_pkg.sv
package mcfu_pkg;

  localparam int VW = 32;
  localparam int QW = 32;
  localparam int ROOT_STEPS = 24;
  localparam int CBRT_STEPS = 22;
  localparam logic [VW-1:0] MAX32 = '1;

  localparam logic [VW-1:0] RST_TIME_STEP = 32'd65536;
  localparam logic [VW-1:0] RST_CHANNEL_WIDTH = 32'd32768;
  localparam logic [VW-1:0] RST_ROUGHNESS = 32'd2294;
  localparam logic [VW-1:0] RST_INFILTRATION = 32'd0;

  typedef enum logic [1:0] {
    CFG_TIME_STEP,
    CFG_CHANNEL_WIDTH,
    CFG_ROUGHNESS,
    CFG_INFILTRATION
  } cfg_idx_t;

  // per-cell payload that travels down the pipeline
  typedef struct packed {
    logic        cmd;
    logic        nb;
    logic [31:0] h;
    logic [31:0] s;
    logic [31:0] l;
    logic [31:0] app_level;
    logic        app_wet;
    logic        sat;
    logic [31:0] x;
    logic [27:0] p;
    logic [23:0] q;
  } item_t;

  // operands of one bit-per-stage division
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] lo;
    logic [33:0] dvs;
  } div_op_t;

  typedef struct packed {
    logic    sat;
    div_op_t op;
  } sat_prep_t;

  // set up (x << 16) / b with saturation at all ones
  function automatic sat_prep_t sat_prep(input logic [31:0] x, input logic [31:0] b);
    sat_prep_t r;
    r.sat = (b != 32'd0) ? ({16'd0, x[31:16]} >= b) : (x != 32'd0);
    r.op.rem = {18'd0, x[31:16]};
    r.op.lo = {x[15:0], 16'd0};
    r.op.dvs = (b == 32'd0) ? 34'd1 : {2'd0, b};
    return r;
  endfunction

  function automatic logic [31:0] sat_hi(input logic [63:0] m);
    return (m[63:48] != 16'd0) ? MAX32 : m[47:16];
  endfunction

endpackage

// File: src/mcfu_div.sv
module mcfu_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  mcfu_pkg::div_op_t   in_op,
  input  mcfu_pkg::item_t     in_item,
  output logic                out_valid,
  output logic [31:0]         out_quo,
  output mcfu_pkg::item_t     out_item
);

  localparam int Steps = mcfu_pkg::QW;

  logic            v_s   [0:Steps];
  logic [33:0]     rem_s [0:Steps];
  logic [31:0]     lo_s  [0:Steps];
  logic [31:0]     quo_s [0:Steps];
  logic [33:0]     dvs_s [0:Steps];
  mcfu_pkg::item_t it_s  [0:Steps];

  assign v_s[0]   = in_valid;
  assign rem_s[0] = in_op.rem;
  assign lo_s[0]  = in_op.lo;
  assign quo_s[0] = '0;
  assign dvs_s[0] = in_op.dvs;
  assign it_s[0]  = in_item;

  // one quotient bit per stage, restoring
  genvar j;
  for (j = 0; j < Steps; j++) begin : g_step
    logic [34:0]     sh;
    logic [34:0]     diff;
    logic            ge;
    logic [33:0]     rem_nxt;
    logic            v_r;
    logic [33:0]     rem_r;
    logic [31:0]     lo_r;
    logic [31:0]     quo_r;
    logic [33:0]     dvs_r;
    mcfu_pkg::item_t it_r;

    always_comb begin
      sh = {rem_s[j], lo_s[j][31]};
      diff = sh - {1'b0, dvs_s[j]};
      ge = (sh >= {1'b0, dvs_s[j]});
      rem_nxt = ge ? diff[33:0] : sh[33:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r <= rem_nxt;
        lo_r <= {lo_s[j][30:0], 1'b0};
        quo_r <= {quo_s[j][30:0], ge};
        dvs_r <= dvs_s[j];
        it_r <= it_s[j];
      end
    end

    assign v_s[j+1]   = v_r;
    assign rem_s[j+1] = rem_r;
    assign lo_s[j+1]  = lo_r;
    assign quo_s[j+1] = quo_r;
    assign dvs_s[j+1] = dvs_r;
    assign it_s[j+1]  = it_r;
  end

  assign out_valid = v_s[Steps];
  assign out_quo   = quo_s[Steps];
  assign out_item  = it_s[Steps];

endmodule

// File: src/mcfu_root.sv
module mcfu_root (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [31:0]     in_ratio,
  input  mcfu_pkg::item_t in_item,
  output logic            out_valid,
  output mcfu_pkg::item_t out_item
);

  localparam int Steps = mcfu_pkg::ROOT_STEPS;
  localparam int CSteps = mcfu_pkg::CBRT_STEPS;

  logic            v_s  [0:Steps];
  logic [31:0]     rt_s [0:Steps];
  logic [21:0]     c_s  [0:Steps];
  logic [43:0]     c2_s [0:Steps];
  logic [63:0]     c3_s [0:Steps];
  logic [23:0]     q_s  [0:Steps];
  logic [47:0]     q2_s [0:Steps];
  mcfu_pkg::item_t it_s [0:Steps];

  assign v_s[0]  = in_valid;
  assign rt_s[0] = in_ratio;
  assign c_s[0]  = '0;
  assign c2_s[0] = '0;
  assign c3_s[0] = '0;
  assign q_s[0]  = '0;
  assign q2_s[0] = '0;
  assign it_s[0] = in_item;

  // square root of slope and cube root of ratio, one result bit per stage,
  // squares and cubes kept up to date with shifted adds
  genvar j;
  for (j = 0; j < Steps; j++) begin : g_step
    localparam int K2 = Steps - 1 - j;
    logic [49:0]     t2q;
    logic            geq;
    logic [23:0]     q_nxt;
    logic [47:0]     q2_nxt;
    logic [21:0]     c_nxt;
    logic [43:0]     c2_nxt;
    logic [63:0]     c3_nxt;
    logic            v_r;
    logic [31:0]     rt_r;
    logic [21:0]     c_r;
    logic [43:0]     c2_r;
    logic [63:0]     c3_r;
    logic [23:0]     q_r;
    logic [47:0]     q2_r;
    mcfu_pkg::item_t it_r;

    always_comb begin
      t2q = {2'd0, q2_s[j]} + ({26'd0, q_s[j]} << (K2 + 1)) + (50'd1 << (2 * K2));
      geq = (t2q <= {2'd0, it_s[j].s, 16'd0});
      q_nxt = geq ? (q_s[j] | (24'd1 << K2)) : q_s[j];
      q2_nxt = geq ? t2q[47:0] : q2_s[j];
    end

    if (j < CSteps) begin : g_cbrt
      localparam int K3 = CSteps - 1 - j;
      logic [67:0] t3;
      logic [45:0] t2c;
      logic        ge3;

      always_comb begin
        t3 = {4'd0, c3_s[j]}
           + (({24'd0, c2_s[j]} + {23'd0, c2_s[j], 1'b0}) << K3)
           + (({46'd0, c_s[j]} + {45'd0, c_s[j], 1'b0}) << (2 * K3))
           + (68'd1 << (3 * K3));
        t2c = {2'd0, c2_s[j]} + ({24'd0, c_s[j]} << (K3 + 1)) + (46'd1 << (2 * K3));
        ge3 = (t3 <= {4'd0, rt_s[j], 32'd0});
        c_nxt = ge3 ? (c_s[j] | (22'd1 << K3)) : c_s[j];
        c2_nxt = ge3 ? t2c[43:0] : c2_s[j];
        c3_nxt = ge3 ? t3[63:0] : c3_s[j];
      end
    end else begin : g_pass
      always_comb begin
        c_nxt = c_s[j];
        c2_nxt = c2_s[j];
        c3_nxt = c3_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_r <= rt_s[j];
        c_r <= c_nxt;
        c2_r <= c2_nxt;
        c3_r <= c3_nxt;
        q_r <= q_nxt;
        q2_r <= q2_nxt;
        it_r <= it_s[j];
      end
    end

    assign v_s[j+1]  = v_r;
    assign rt_s[j+1] = rt_r;
    assign c_s[j+1]  = c_r;
    assign c2_s[j+1] = c2_r;
    assign c3_s[j+1] = c3_r;
    assign q_s[j+1]  = q_r;
    assign q2_s[j+1] = q2_r;
    assign it_s[j+1] = it_r;
  end

  // ratio^(2/3) from the square of the cube root
  always_comb begin
    out_item = it_s[Steps];
    out_item.p = c2_s[Steps][43:16];
    out_item.q = q_s[Steps];
  end

  assign out_valid = v_s[Steps];

endmodule

// File: src/mcfu_mul.sv
module mcfu_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic [31:0]     time_step,
  input  logic            in_valid,
  input  mcfu_pkg::item_t in_item,
  output logic            out_valid,
  output mcfu_pkg::item_t out_item
);

  logic [3:0]      v_r;
  logic [63:0]     m1_r;
  logic [63:0]     m2_r;
  logic [63:0]     m3_r;
  mcfu_pkg::item_t it1_r;
  mcfu_pkg::item_t it2_r;
  mcfu_pkg::item_t it3_r;
  mcfu_pkg::item_t it4_r;
  mcfu_pkg::item_t it4_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_comb begin
    it4_nxt = it3_r;
    it4_nxt.x = mcfu_pkg::sat_hi(m3_r);
  end

  // h*p, then *sqrt(s), then *dt, each saturated
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= {32'd0, in_item.h} * {36'd0, in_item.p};
      it1_r <= in_item;
      m2_r <= {32'd0, mcfu_pkg::sat_hi(m1_r)} * {40'd0, it1_r.q};
      it2_r <= it1_r;
      m3_r <= {32'd0, mcfu_pkg::sat_hi(m2_r)} * {32'd0, time_step};
      it3_r <= it2_r;
      it4_r <= it4_nxt;
    end
  end

  assign out_valid = v_r[3];
  assign out_item = it4_r;

endmodule

// File: src/mcfu_front.sv
module mcfu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [31:0]       time_step,
  input  logic [31:0]       channel_width,
  input  logic [31:0]       infiltration_rate,
  input  logic              in_valid,
  input  mcfu_pkg::item_t   in_item,
  input  logic [31:0]       in_inflow,
  input  logic [31:0]       in_rain,
  output logic              out_valid,
  output mcfu_pkg::item_t   out_item,
  output mcfu_pkg::div_op_t out_op
);

  logic              v1_r;
  logic              v2_r;
  mcfu_pkg::item_t   it1_r;
  logic [63:0]       wh1_r;
  logic [33:0]       d1_r;
  logic [63:0]       rd1_r;
  logic [63:0]       id1_r;
  logic [31:0]       inflow1_r;
  logic              rain_nz1_r;
  logic [48:0]       add;
  logic [48:0]       sub;
  logic [48:0]       lvl;
  mcfu_pkg::item_t   it2_nxt;
  mcfu_pkg::item_t   it2_r;
  mcfu_pkg::div_op_t op2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // products for the hydraulic radius and the apply terms
  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r <= in_item;
      wh1_r <= {32'd0, channel_width} * {32'd0, in_item.h};
      d1_r <= {2'd0, channel_width} + {1'b0, in_item.h, 1'b0};
      rd1_r <= {32'd0, in_rain} * {32'd0, time_step};
      id1_r <= {32'd0, infiltration_rate} * {32'd0, time_step};
      inflow1_r <= in_inflow;
      rain_nz1_r <= (in_rain != 32'd0);
    end
  end

  // apply-mode level, floored at zero and saturated
  always_comb begin
    add = {17'd0, it1_r.h} + {17'd0, inflow1_r} + {1'b0, rd1_r[63:16]};
    sub = {1'b0, id1_r[63:16]};
    lvl = (add > sub) ? (add - sub) : '0;
    it2_nxt = it1_r;
    it2_nxt.app_level = (lvl[48:32] != 17'd0) ? mcfu_pkg::MAX32 : lvl[31:0];
    it2_nxt.app_wet = (it2_nxt.app_level != 32'd0) || rain_nz1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it2_r <= it2_nxt;
      op2_r.rem <= {2'd0, wh1_r[63:32]};
      op2_r.lo <= wh1_r[31:0];
      op2_r.dvs <= d1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_item = it2_r;
  assign out_op = op2_r;

endmodule

// File: src/manning_cell_flow_update_top.sv
// channel   dir   handshake            payload
// in_       in    in_tvalid/tready     cmd in tuser, cell fields in tdata
// out_      out   out_tvalid/tready    new level, outflow, wet in tdata
// cfg_      in    cfg_we               register index and write data
//
// one cell per cycle unless a pending result is not taken; a request passes through the stages
// (2 front, 32 ratio divide, 24 root, 4 multiply, 32 + 32 divide, 1 output),
// set by the one-bit-per-stage dividers and root extraction
// reset clears all valid bits and loads the register defaults
// when the output request is not taken, the whole pipeline holds in place
`include "manning_cell_flow_update_top_defines.svh"

module manning_cell_flow_update_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // level[31:0], slope[63:32], distance[95:64], has_neighbor[96],
  // inflow[128:97], rain[160:129], zero fill
  input  logic [167:0] in_tdata,
  // cmd[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_level[31:0], outflow[63:32], wet[64], zero fill
  output logic [71:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  logic              adv;
  logic [31:0]       dt_r;
  logic [31:0]       w_r;
  logic [31:0]       rough_r;
  logic [31:0]       inf_r;
  mcfu_pkg::item_t   in_item;
  logic              fr_v;
  mcfu_pkg::item_t   fr_it;
  mcfu_pkg::div_op_t fr_op;
  logic              d0_v;
  logic [31:0]       d0_q;
  mcfu_pkg::item_t   d0_it;
  logic              rt_v;
  mcfu_pkg::item_t   rt_it;
  logic              mu_v;
  mcfu_pkg::item_t   mu_it;
  mcfu_pkg::sat_prep_t pr1;
  mcfu_pkg::item_t   d1_in;
  logic              d1_v;
  logic [31:0]       d1_q;
  mcfu_pkg::item_t   d1_it;
  logic [31:0]       x1;
  mcfu_pkg::sat_prep_t pr2;
  mcfu_pkg::item_t   d2_in;
  logic              d2_v;
  logic [31:0]       d2_q;
  mcfu_pkg::item_t   d2_it;
  logic [31:0]       x2;
  logic              flow;
  logic [31:0]       oflow_nxt;
  logic [31:0]       lvl_nxt;
  logic              ov_r;
  logic [31:0]       lvl_r;
  logic [31:0]       oflow_r;
  logic              wet_r;

  assign adv = !ov_r || out_tready;
  assign in_tready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= mcfu_pkg::RST_TIME_STEP;
      w_r <= mcfu_pkg::RST_CHANNEL_WIDTH;
      rough_r <= mcfu_pkg::RST_ROUGHNESS;
      inf_r <= mcfu_pkg::RST_INFILTRATION;
    end else if (cfg_we) begin
      case (mcfu_pkg::cfg_idx_t'(cfg_addr))
        mcfu_pkg::CFG_TIME_STEP: dt_r <= cfg_wdata;
        mcfu_pkg::CFG_CHANNEL_WIDTH: w_r <= cfg_wdata;
        mcfu_pkg::CFG_ROUGHNESS: rough_r <= cfg_wdata;
        mcfu_pkg::CFG_INFILTRATION: inf_r <= cfg_wdata;
        default: dt_r <= dt_r;
      endcase
    end
  end

  // unpack the request
  always_comb begin
    in_item = '0;
    in_item.cmd = in_tuser;
    in_item.h = in_tdata[31:0];
    in_item.s = in_tdata[63:32];
    in_item.l = in_tdata[95:64];
    in_item.nb = in_tdata[96];
  end

  mcfu_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .time_step(dt_r), .channel_width(w_r), .infiltration_rate(inf_r),
    .in_valid(in_tvalid), .in_item(in_item),
    .in_inflow(in_tdata[128:97]), .in_rain(in_tdata[160:129]),
    .out_valid(fr_v), .out_item(fr_it), .out_op(fr_op)
  );

  // hydraulic radius w*h / (w + 2h)
  mcfu_div u_div_ratio (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(fr_v), .in_op(fr_op), .in_item(fr_it),
    .out_valid(d0_v), .out_quo(d0_q), .out_item(d0_it)
  );

  mcfu_root u_root (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(d0_v), .in_ratio(d0_q), .in_item(d0_it),
    .out_valid(rt_v), .out_item(rt_it)
  );

  mcfu_mul u_mul (
    .clk(clk), .rst_n(rst_n), .adv(adv), .time_step(dt_r),
    .in_valid(rt_v), .in_item(rt_it),
    .out_valid(mu_v), .out_item(mu_it)
  );

  // divide by distance
  always_comb begin
    pr1 = mcfu_pkg::sat_prep(mu_it.x, mu_it.l);
    d1_in = mu_it;
    d1_in.sat = pr1.sat;
  end

  mcfu_div u_div_dist (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(mu_v), .in_op(pr1.op), .in_item(d1_in),
    .out_valid(d1_v), .out_quo(d1_q), .out_item(d1_it)
  );

  // divide by roughness
  always_comb begin
    x1 = d1_it.sat ? mcfu_pkg::MAX32 : d1_q;
    pr2 = mcfu_pkg::sat_prep(x1, rough_r);
    d2_in = d1_it;
    d2_in.x = x1;
    d2_in.sat = pr2.sat;
  end

  mcfu_div u_div_rough (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(d1_v), .in_op(pr2.op), .in_item(d2_in),
    .out_valid(d2_v), .out_quo(d2_q), .out_item(d2_it)
  );

  // clamp to the level and pick the result of the mode
  always_comb begin
    x2 = d2_it.sat ? mcfu_pkg::MAX32 : d2_q;
    flow = !d2_it.cmd && d2_it.nb && (d2_it.h != 32'd0);
    oflow_nxt = flow ? ((x2 < d2_it.h) ? x2 : d2_it.h) : 32'd0;
    lvl_nxt = d2_it.cmd ? d2_it.app_level : (d2_it.h - oflow_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lvl_r <= lvl_nxt;
      oflow_r <= oflow_nxt;
      wet_r <= d2_it.cmd && d2_it.app_wet;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, wet_r, oflow_r, lvl_r};

  // checks
  `MCFU_ASSERT_IMP(a_wet_no_outflow, out_tvalid && out_tdata[64], out_tdata[63:32] == 32'd0, "wet result carries outflow")
  `MCFU_ASSERT_IMP(a_stall_has_result, !in_tready, out_tvalid, "input stalled with no pending result")
  `MCFU_ASSERT_IMP(a_reset_empty, !$past(rst_n), !out_tvalid, "result valid right after reset")
  `MCFU_ASSERT_ALWAYS(a_zero_fill, out_tdata[71:65] == 7'd0, "result fill bits not zero")

endmodule

// File: verif/manning_cell_flow_update_top_tb.sv
`timescale 1ns / 100ps

module manning_cell_flow_update_top_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // level, slope, distance, has_neighbor, inflow, rain, zero fill
  logic [167:0] in_tdata;
  // cmd
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  // new_level, outflow, wet, zero fill
  logic [71:0]  out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;

  manning_cell_flow_update_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic [31:0] new_level;
    logic [31:0] outflow;
    logic        wet;
  } cell_res_t;

  // expected cell results, with a private copy of the registers
  class cell_scoreboard;
    logic [63:0] dt, w, r, infil;
    cell_res_t   pending[$];
    int          errors;

    function new();
      dt = mcfu_pkg::RST_TIME_STEP;
      w = mcfu_pkg::RST_CHANNEL_WIDTH;
      r = mcfu_pkg::RST_ROUGHNESS;
      infil = mcfu_pkg::RST_INFILTRATION;
      errors = 0;
    endfunction

    function void set_reg(mcfu_pkg::cfg_idx_t idx, logic [31:0] v);
      case (idx)
        mcfu_pkg::CFG_TIME_STEP:     dt = v;
        mcfu_pkg::CFG_CHANNEL_WIDTH: w = v;
        mcfu_pkg::CFG_ROUGHNESS:     r = v;
        default:                     infil = v;
      endcase
    endfunction

    function logic [63:0] mul_clip(logic [63:0] a, logic [63:0] b);
      logic [63:0] v;
      v = (a * b) >> 16;
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function logic [63:0] div_clip(logic [63:0] a, logic [63:0] b);
      logic [63:0] v;
      if (b == 0) return (a == 0) ? 64'd0 : 64'hFFFF_FFFF;
      v = (a << 16) / b;
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function logic [63:0] cube_root(logic [63:0] n);
      logic [63:0] lo, hi, mid;
      lo = 0; hi = 64'd2642245;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (mid * mid * mid <= n) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function logic [63:0] square_root(logic [63:0] n);
      logic [63:0] q, t;
      q = 0;
      for (int b = 23; b >= 0; b--) begin
        t = q | (64'd1 << b);
        if (t * t <= n) q = t;
      end
      return q;
    endfunction

    // work out the result of one accepted request
    function void note_request(logic cmd, logic [167:0] d);
      logic [63:0] h, s, l, infl, rain, ratio, c, p, q, x, add, sub, v;
      cell_res_t e;
      h = d[31:0]; s = d[63:32]; l = d[95:64]; infl = d[128:97]; rain = d[160:129];
      e.new_level = h; e.outflow = 0; e.wet = 0;
      if (!cmd) begin
        if (d[96] && h > 0) begin
          ratio = (w * h) / (w + 2 * h);
          c = cube_root(ratio << 32);
          p = (c * c) >> 16;
          q = square_root(s << 16);
          x = mul_clip(mul_clip(mul_clip(h, p), q), dt);
          x = div_clip(div_clip(x, l), r);
          if (x > h) x = h;
          e.outflow = x;
          e.new_level = h - x;
        end
      end else begin
        add = h + infl + ((rain * dt) >> 16);
        sub = (infil * dt) >> 16;
        v = (add > sub) ? add - sub : 0;
        e.new_level = (v > 64'hFFFF_FFFF) ? ALL1 : v[31:0];
        e.wet = (e.new_level != 0) || (rain != 0);
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [71:0] d);
      cell_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.new_level) begin
        $error("new_level: expected %h, got %h", e.new_level, d[31:0]); errors++;
      end
      if (d[63:32] !== e.outflow) begin
        $error("outflow: expected %h, got %h", e.outflow, d[63:32]); errors++;
      end
      if (d[64] !== e.wet) begin
        $error("wet: expected %b, got %b", e.wet, d[64]); errors++;
      end
    endfunction
  endclass

  cell_scoreboard sb;
  bit no_idle;
  bit hold_req;

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    bit ok;
    int n;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk); ok = out_tvalid;
        @(posedge clk);
      end while (!ok);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_cell(logic cmd, logic [31:0] h, logic [31:0] s, logic [31:0] l,
                           logic nb, logic [31:0] infl, logic [31:0] rain);
    int  gap;
    bit  ok;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, rain, infl, nb, l, s, h};
    do begin
      @(negedge clk); ok = in_tready;
      if (ok) sb.note_request(in_tuser, in_tdata);
      @(posedge clk);
    end while (!ok);
  endtask

  // register write while the pipeline is drained
  task automatic write_reg(mcfu_pkg::cfg_idx_t idx, logic [31:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 4))
      0: return ($urandom_range(0, 1) != 0) ? ALL1 : 32'd0;
      1: return $urandom_range(0, 32'h3_FFFF);
      2: return $urandom_range(0, 32'hFF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_cfg();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 32'h2_0000);
      1: return $urandom_range(1, 32'hFF_FFFF);
      default: return $urandom() | 32'd1;
    endcase
  endfunction

  task automatic random_cells(int count);
    logic [31:0] l;
    for (int i = 0; i < count; i++) begin
      l = ($urandom_range(0, 15) == 0) ? 32'd0 : pick32();
      send_cell($urandom_range(0, 2) == 0, pick32(), pick32(), l,
                $urandom_range(0, 5) != 0, pick32(), pick32());
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
    end
    no_idle = 0;
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0; in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0;
    cfg_we = 1'b0; cfg_addr = mcfu_pkg::CFG_TIME_STEP; cfg_wdata = '0;
    no_idle = 0; hold_req = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, then extreme register settings
    send_cell(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 0, 0); // no neighbour
    send_cell(1'b0, 32'd0, 32'h0001_0000, 32'h0001_0000, 1'b1, 0, 0);         // empty cell
    send_cell(1'b0, 32'h0002_0000, 32'h0000_4000, 32'h0004_0000, 1'b1, 0, 0);
    send_cell(1'b0, ALL1, ALL1, ALL1, 1'b1, ALL1, ALL1);
    send_cell(1'b0, 32'h0001_0000, 32'd0, 32'h0001_0000, 1'b1, 0, 0);         // flat
    send_cell(1'b0, 32'h0001_0000, ALL1, 32'd0, 1'b1, 0, 0);                  // zero distance
    send_cell(1'b0, 32'd1, 32'd1, ALL1, 1'b1, 0, 0);
    send_cell(1'b1, 32'd0, 0, 0, 1'b0, 32'd0, 32'd0);                         // dry cell
    send_cell(1'b1, 32'd0, 0, 0, 1'b0, 32'd0, 32'd1);
    send_cell(1'b1, ALL1, ALL1, ALL1, 1'b1, ALL1, ALL1);                      // overflow
    send_cell(1'b1, 32'h0001_2345, 0, 0, 1'b0, 32'h0000_8000, 32'h0000_0100);
    write_reg(mcfu_pkg::CFG_INFILTRATION, ALL1);
    send_cell(1'b1, 32'h0001_0000, 0, 0, 1'b0, 32'h0001_0000, 32'd0);         // underflow
    send_cell(1'b1, ALL1, 0, 0, 1'b0, 32'd0, ALL1);
    write_reg(mcfu_pkg::CFG_TIME_STEP, 32'd0);
    send_cell(1'b1, 32'h0000_0001, 0, 0, 1'b0, 0, ALL1);
    send_cell(1'b0, 32'h0005_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 0, 0);
    write_reg(mcfu_pkg::CFG_TIME_STEP, ALL1);
    write_reg(mcfu_pkg::CFG_CHANNEL_WIDTH, ALL1);
    write_reg(mcfu_pkg::CFG_ROUGHNESS, 32'd1);
    send_cell(1'b0, 32'h0003_0000, 32'h0000_1000, 32'h0001_0000, 1'b1, 0, 0);
    write_reg(mcfu_pkg::CFG_CHANNEL_WIDTH, 32'd1);
    write_reg(mcfu_pkg::CFG_ROUGHNESS, ALL1);
    send_cell(1'b0, ALL1, ALL1, 32'd1, 1'b1, 0, 0);
    send_cell(1'b0, 32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 1'b1, 0, 0);

    // random phases over several register settings
    write_reg(mcfu_pkg::CFG_TIME_STEP, mcfu_pkg::RST_TIME_STEP);
    write_reg(mcfu_pkg::CFG_CHANNEL_WIDTH, mcfu_pkg::RST_CHANNEL_WIDTH);
    write_reg(mcfu_pkg::CFG_ROUGHNESS, mcfu_pkg::RST_ROUGHNESS);
    write_reg(mcfu_pkg::CFG_INFILTRATION, mcfu_pkg::RST_INFILTRATION);
    random_cells(150);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(mcfu_pkg::CFG_TIME_STEP, (ph == 1) ? 32'd0 : (ph == 2) ? ALL1 : pick_cfg());
      write_reg(mcfu_pkg::CFG_CHANNEL_WIDTH,
                (ph == 3) ? 32'd1 : (ph == 4) ? ALL1 : pick_cfg());
      write_reg(mcfu_pkg::CFG_ROUGHNESS, (ph == 3) ? ALL1 : (ph == 4) ? 32'd1 : pick_cfg());
      write_reg(mcfu_pkg::CFG_INFILTRATION,
                (ph == 5) ? ALL1 : $urandom_range(0, 32'h2_0000));
      if (ph == 2) hold_req = 1;
      random_cells(110);
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/mcfu_pkg.sv
src/mcfu_div.sv
src/mcfu_root.sv
src/mcfu_mul.sv
src/mcfu_front.sv
src/manning_cell_flow_update_top.sv
verif/manning_cell_flow_update_top_tb.sv
